// ===== rtl/core/durg_pkg.sv =====
// Shared types and constants for the uniform random draw unit.
package durg_pkg;

  localparam int unsigned MAG_W     = 128;
  localparam int unsigned FRAC_BITS = 80;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [31:0] LCG_MUL       = 32'd69069;
  localparam logic [31:0] ZERO_SEED_SUB = 32'd259341593;
  localparam logic [31:0] DIV_K         = 32'hFFFF_FFFF;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    MODE_EMPTY,
    MODE_LOW,
    MODE_TOP,
    MODE_FULL
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [31:0]        seed;
  } item_t;

endpackage

// ===== rtl/core/durg_front.sv =====
// Front end: takes input beats and sorts them by range case.
module durg_front (
  input  logic                 in_valid,
  input  logic [31:0]          in_seed_in,
  input  logic signed [31:0]   in_range_start,
  input  logic signed [31:0]   in_range_end,
  input  logic                 fifo_full,
  output logic                 in_ready,
  output logic                 push,
  output durg_pkg::item_t      push_item
);
  import durg_pkg::*;

  assign in_ready = !fifo_full;
  assign push     = in_valid && !fifo_full;

  always_comb begin
    push_item.lo   = in_range_start;
    push_item.hi   = in_range_end;
    push_item.seed = in_seed_in;
    priority if (in_range_start >= in_range_end) begin
      push_item.mode = MODE_EMPTY;
    end else if (in_range_end != INT_MAX) begin
      push_item.mode = MODE_LOW;
    end else if (in_range_start != INT_MIN) begin
      push_item.mode = MODE_TOP;
    end else begin
      push_item.mode = MODE_FULL;
    end
  end

endmodule

// ===== rtl/core/durg_fifo.sv =====
// Short queue between the front end and the arithmetic pipeline.
module durg_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  durg_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output durg_pkg::item_t head_item
);
  import durg_pkg::*;

  item_t                   mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]        count_r, count_nxt;

  assign full      = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty)) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue count out of range");

endmodule

// ===== rtl/core/durg_rnd.sv =====
// Signed add of a whole number, then round to 53 significant bits (3 stages).
module durg_rnd (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  durg_pkg::item_t               in_item,
  input  logic                          in_neg,
  input  logic [durg_pkg::MAG_W-1:0]    in_mag,
  input  logic signed [33:0]            in_add,
  input  logic                          in_sticky,
  output logic                          out_valid,
  output durg_pkg::item_t               out_item,
  output logic                          out_neg,
  output logic [durg_pkg::MAG_W-1:0]    out_mag
);
  import durg_pkg::*;

  logic               b_neg;
  logic [33:0]        b_abs;
  logic [MAG_W-1:0]   b_mag;
  logic [MAG_W-1:0]   sum;
  logic               sum_neg;

  logic               a_valid_r;
  item_t              a_item_r;
  logic               a_neg_r;
  logic [MAG_W-1:0]   a_mag_r;
  logic               a_sticky_r;

  logic [7:0]         h;
  logic               c_valid_r;
  item_t              c_item_r;
  logic               c_neg_r;
  logic [MAG_W-1:0]   c_mag_r;
  logic               c_sticky_r;
  logic [7:0]         c_h_r;

  logic [6:0]         sh;
  logic [MAG_W-1:0]   mask;
  logic [MAG_W-1:0]   half;
  logic [MAG_W-1:0]   rem;
  logic               inc;
  logic [MAG_W-1:0]   rounded;

  logic               o_valid_r;
  item_t              o_item_r;
  logic               o_neg_r;
  logic [MAG_W-1:0]   o_mag_r;

  always_comb begin
    b_neg = in_add[33];
    b_abs = b_neg ? 34'(-in_add) : 34'(in_add);
    b_mag = {14'd0, b_abs, 80'd0};
    if (in_neg == b_neg) begin
      sum     = in_mag + b_mag;
      sum_neg = in_neg;
    end else if (in_mag >= b_mag) begin
      sum     = in_mag - b_mag;
      sum_neg = in_neg;
    end else begin
      sum     = b_mag - in_mag;
      sum_neg = b_neg;
    end
    if (sum == '0) begin
      sum_neg = 1'b0;
    end
  end

  always_comb begin
    h = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (a_mag_r[i]) begin
        h = 8'(i + 1);
      end
    end
  end

  always_comb begin
    sh      = 7'(c_h_r - 8'd53);
    mask    = (MAG_W'(1) << sh) - MAG_W'(1);
    half    = MAG_W'(1) << (sh - 7'd1);
    rem     = c_mag_r & mask;
    inc     = (rem > half) || ((rem == half) && (c_sticky_r || c_mag_r[sh]));
    rounded = (c_mag_r & ~mask) + (inc ? (mask + MAG_W'(1)) : '0);
    if (c_h_r <= 8'd53) begin
      rounded = c_mag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      c_valid_r <= a_valid_r;
      o_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item_r   <= in_item;
      a_neg_r    <= sum_neg;
      a_mag_r    <= sum;
      a_sticky_r <= in_sticky;
      c_item_r   <= a_item_r;
      c_neg_r    <= a_neg_r;
      c_mag_r    <= a_mag_r;
      c_sticky_r <= a_sticky_r;
      c_h_r      <= h;
      o_item_r   <= c_item_r;
      o_neg_r    <= c_neg_r;
      o_mag_r    <= rounded;
    end
  end

  assign out_valid = o_valid_r;
  assign out_item  = o_item_r;
  assign out_neg   = o_neg_r;
  assign out_mag   = o_mag_r;

endmodule

// ===== rtl/core/durg_back.sv =====
// Back end: seed step, scaled draw with binary64-exact rounding, floor and clamp.
module durg_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               f_valid,
  input  durg_pkg::item_t    f_item,
  output logic               f_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [31:0]        out_seed_out
);
  import durg_pkg::*;

  logic en;

  logic               s1_valid_r;
  item_t              s1_item_r;
  item_t              s1_item_nxt;
  logic [31:0]        old_seed;
  logic [31:0]        new_seed;

  logic signed [33:0] lo_eff;
  logic signed [33:0] d_full;
  logic [32:0]        d_span;
  logic [22:0]        m;
  logic [46:0]        frac;
  logic               s2_valid_r;
  item_t              s2_item_r;
  logic [56:0]        pp_lo_r;
  logic [56:0]        pp_hi_r;

  logic               s3_valid_r;
  item_t              s3_item_r;
  logic [MAG_W-1:0]   s3_mag_r;
  logic [79:0]        prod;

  logic               r0_valid, r1_valid, r2_valid, rd_valid, r3_valid, r4_valid;
  item_t              r0_item, r1_item, r2_item, rd_item, r3_item, r4_item;
  logic               r0_neg, r1_neg, r2_neg, rd_neg, r3_neg, r4_neg;
  logic [MAG_W-1:0]   r0_mag, r1_mag, r2_mag, rd_mag, r3_mag, r4_mag;
  logic signed [33:0] add1, add2, add3, add4;
  logic [MAG_W-1:0]   r3_in_mag;

  logic               dv_valid_r [1:4];
  item_t              dv_item_r  [1:4];
  logic               dv_neg_r   [1:4];
  logic [MAG_W-1:0]   dv_mag_r   [1:4];
  logic [MAG_W-1:0]   dv_q_r     [1:4];
  logic [31:0]        dv_r_r     [1:4];
  logic [MAG_W-1:0]   rd_in_mag;
  logic               rd_in_sticky;

  logic [47:0]        whole;
  logic signed [49:0] ival;
  logic signed [49:0] clamped;
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic [31:0]        out_seed_r;

  assign en    = !out_valid_r || out_ready;
  assign f_pop = en && f_valid;

  // seed step
  always_comb begin
    old_seed    = (f_item.seed != '0) ? f_item.seed : ZERO_SEED_SUB;
    new_seed    = old_seed * LCG_MUL + 32'd1;
    s1_item_nxt = f_item;
    if (f_item.mode != MODE_EMPTY) begin
      s1_item_nxt.seed = new_seed;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  // span and fraction, split product
  always_comb begin
    lo_eff = (s1_item_r.mode == MODE_TOP) ? (34'(s1_item_r.lo) - 34'sd1) : 34'(s1_item_r.lo);
    d_full = 34'(s1_item_r.hi) - lo_eff + ((s1_item_r.mode == MODE_LOW) ? 34'sd1 : 34'sd0);
    d_span = d_full[32:0];
    m      = s1_item_r.seed[31:9];
    frac   = {24'(m) + 24'd1, m};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_item_r <= s1_item_r;
      pp_lo_r   <= 57'(d_span) * 57'(frac[23:0]);
      pp_hi_r   <= 57'(d_span) * 57'(frac[46:24]);
    end
  end

  assign prod = (80'(pp_hi_r) << 24) + 80'(pp_lo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_item_r <= s2_item_r;
      s3_mag_r  <= {14'd0, prod, 34'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= f_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  durg_rnd u_rnd_prod (
    .clk, .rst_n, .en,
    .in_valid(s3_valid_r), .in_item(s3_item_r), .in_neg(1'b0), .in_mag(s3_mag_r),
    .in_add('0), .in_sticky(1'b0),
    .out_valid(r0_valid), .out_item(r0_item), .out_neg(r0_neg), .out_mag(r0_mag)
  );

  always_comb begin
    add1 = (r0_item.mode == MODE_TOP) ? (34'(r0_item.lo) - 34'sd1) : 34'(r0_item.lo);
  end

  durg_rnd u_rnd_base (
    .clk, .rst_n, .en,
    .in_valid(r0_valid), .in_item(r0_item), .in_neg(r0_neg), .in_mag(r0_mag),
    .in_add(add1), .in_sticky(1'b0),
    .out_valid(r1_valid), .out_item(r1_item), .out_neg(r1_neg), .out_mag(r1_mag)
  );

  always_comb begin
    unique case (r1_item.mode)
      MODE_TOP:  add2 = 34'sd1;
      MODE_FULL: add2 = 34'sd2147483648;
      default:   add2 = 34'sd0;
    endcase
  end

  durg_rnd u_rnd_shift (
    .clk, .rst_n, .en,
    .in_valid(r1_valid), .in_item(r1_item), .in_neg(r1_neg), .in_mag(r1_mag),
    .in_add(add2), .in_sticky(1'b0),
    .out_valid(r2_valid), .out_item(r2_item), .out_neg(r2_neg), .out_mag(r2_mag)
  );

  // divide by 2^32-1, one 32-bit limb per stage
  for (genvar k = 1; k <= 4; k++) begin : g_div
    logic               p_valid;
    item_t              p_item;
    logic               p_neg;
    logic [MAG_W-1:0]   p_mag;
    logic [MAG_W-1:0]   p_q;
    logic [31:0]        p_r;
    logic [32:0]        s;
    logic               t;
    logic [MAG_W-1:0]   q_nxt;
    if (k == 1) begin : g_first
      assign p_valid = r2_valid;
      assign p_item  = r2_item;
      assign p_neg   = r2_neg;
      assign p_mag   = r2_mag;
      assign p_q     = '0;
      assign p_r     = '0;
    end else begin : g_rest
      assign p_valid = dv_valid_r[k-1];
      assign p_item  = dv_item_r[k-1];
      assign p_neg   = dv_neg_r[k-1];
      assign p_mag   = dv_mag_r[k-1];
      assign p_q     = dv_q_r[k-1];
      assign p_r     = dv_r_r[k-1];
    end
    always_comb begin
      s     = {1'b0, p_r} + {1'b0, p_mag[MAG_W-1-32*(k-1) -: 32]};
      t     = (s >= {1'b0, DIV_K});
      q_nxt = p_q;
      q_nxt[MAG_W-1-32*(k-1) -: 32] = p_r + 32'(t);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k] <= 1'b0;
      end else if (en) begin
        dv_valid_r[k] <= p_valid;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_item_r[k] <= p_item;
        dv_neg_r[k]  <= p_neg;
        dv_mag_r[k]  <= p_mag;
        dv_q_r[k]    <= q_nxt;
        dv_r_r[k]    <= t ? 32'(s - {1'b0, DIV_K}) : s[31:0];
      end
    end
  end

  always_comb begin
    rd_in_mag    = (dv_item_r[4].mode == MODE_FULL) ? dv_q_r[4] : dv_mag_r[4];
    rd_in_sticky = (dv_item_r[4].mode == MODE_FULL) && (dv_r_r[4] != '0);
  end

  durg_rnd u_rnd_div (
    .clk, .rst_n, .en,
    .in_valid(dv_valid_r[4]), .in_item(dv_item_r[4]), .in_neg(dv_neg_r[4]),
    .in_mag(rd_in_mag), .in_add('0), .in_sticky(rd_in_sticky),
    .out_valid(rd_valid), .out_item(rd_item), .out_neg(rd_neg), .out_mag(rd_mag)
  );

  always_comb begin
    r3_in_mag = (rd_item.mode == MODE_FULL) ? (rd_mag << 32) : rd_mag;
    add3      = (rd_item.mode == MODE_FULL) ? -34'sd2147483648 : 34'sd0;
  end

  durg_rnd u_rnd_unshift (
    .clk, .rst_n, .en,
    .in_valid(rd_valid), .in_item(rd_item), .in_neg(rd_neg), .in_mag(r3_in_mag),
    .in_add(add3), .in_sticky(1'b0),
    .out_valid(r3_valid), .out_item(r3_item), .out_neg(r3_neg), .out_mag(r3_mag)
  );

  // floor: negative reals step down by one before truncation
  assign add4 = r3_neg ? -34'sd1 : 34'sd0;

  durg_rnd u_rnd_floor (
    .clk, .rst_n, .en,
    .in_valid(r3_valid), .in_item(r3_item), .in_neg(r3_neg), .in_mag(r3_mag),
    .in_add(add4), .in_sticky(1'b0),
    .out_valid(r4_valid), .out_item(r4_item), .out_neg(r4_neg), .out_mag(r4_mag)
  );

  always_comb begin
    whole   = r4_mag[MAG_W-1:FRAC_BITS];
    ival    = r4_neg ? -$signed({2'b00, whole}) : $signed({2'b00, whole});
    clamped = ival;
    if (ival < 50'(r4_item.lo)) begin
      clamped = 50'(r4_item.lo);
    end
    if (ival > 50'(r4_item.hi)) begin
      clamped = 50'(r4_item.hi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= r4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_seed_r  <= r4_item.seed;
      out_value_r <= (r4_item.mode == MODE_EMPTY) ? r4_item.lo : clamped[31:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_seed_out = out_seed_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s1_valid_r) && $stable(s3_valid_r) && $stable(out_valid_r))
    else $error("pipeline moved while stalled");
  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    en && !f_valid |=> !s1_valid_r) else $error("stage 1 filled without a beat");
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid_r[4] |-> dv_r_r[4] != DIV_K) else $error("divide remainder not reduced");

endmodule

// ===== rtl/core/dist_uniform_random_generator_unit.sv =====
// Top level of the uniform random draw unit.
// Usage:
//   Input channel (in_valid/in_ready): one beat carries a seed and an inclusive
//   signed range. Output channel (out_valid/out_ready): one beat per input beat,
//   the drawn value and the updated seed, in input order.
//   An empty range (start >= end) returns start and passes the seed unchanged.
// Throughput: one beat per cycle while the receiver takes results.
// Pipeline: seed multiply, split span product, six add-and-round segments of
//   three stages each, four divide stages and the output register.
// A four-entry queue sits between input and pipeline; in_ready drops only when
//   it is full.
// Stall: when out_ready is low with a result held, the whole pipeline holds;
//   the queue keeps taking beats until it fills.
// Reset: synchronous, active low; empties the queue and all stage valids.
module dist_uniform_random_generator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_seed_in,
  input  logic signed [31:0] in_range_start,
  input  logic signed [31:0] in_range_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [31:0]        out_seed_out
);
  import durg_pkg::*;

  logic  push;
  item_t push_item;
  logic  fifo_full;
  logic  fifo_not_empty;
  logic  pop;
  item_t head_item;

  durg_front u_front (
    .in_valid, .in_seed_in, .in_range_start, .in_range_end,
    .fifo_full, .in_ready, .push, .push_item
  );

  durg_fifo u_fifo (
    .clk, .rst_n, .push, .push_item, .pop,
    .full(fifo_full), .not_empty(fifo_not_empty), .head_item
  );

  durg_back u_back (
    .clk, .rst_n,
    .f_valid(fifo_not_empty), .f_item(head_item), .f_pop(pop),
    .out_valid, .out_ready, .out_value, .out_seed_out
  );

endmodule
